FILE: src/qhd_pkg.sv
package qhd_pkg;

  // Model word layout
  localparam int WORD_W    = 32;
  localparam int IDX_W     = 5;
  localparam int DIST_W    = 31;
  localparam int NUM_WORDS = 18;
  localparam int NUM_COEF  = 6;
  localparam int NUM_ROT   = 9;
  localparam int SLOT_ROT  = 6;
  localparam int SLOT_CEN  = 15;

  // Width used for saturation input
  localparam int SAT_IN_W  = 72;

  // Action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [DIST_W-1:0]        dist_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic word_t sat32(logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'(signed'({1'b0, {(WORD_W-1){1'b1}}}));
    lo = SAT_IN_W'(signed'({1'b1, {(WORD_W-1){1'b0}}}));
    if (v > hi) begin
      return word_t'({1'b0, {(WORD_W-1){1'b1}}});
    end else if (v < lo) begin
      return word_t'({1'b1, {(WORD_W-1){1'b0}}});
    end else begin
      return v[WORD_W-1:0];
    end
  endfunction

endpackage

FILE: src/qhd_stream_if.sv
// Input channel: load or query beats
interface qhd_in_if;
  logic            valid;
  logic            ready;
  logic            action;
  qhd_pkg::idx_t   word_index;
  qhd_pkg::word_t  word_value;
  qhd_pkg::word_t  point_x;
  qhd_pkg::word_t  point_y;
  qhd_pkg::word_t  point_z;

  modport source (output valid, action, word_index, word_value, point_x, point_y, point_z,
                  input ready);
  modport sink   (input valid, action, word_index, word_value, point_x, point_y, point_z,
                  output ready);
endinterface

// Output channel: distance beats
interface qhd_out_if;
  logic            valid;
  logic            ready;
  qhd_pkg::dist_t  distance;

  modport source (output valid, distance, input ready);
  modport sink   (input valid, distance, output ready);
endinterface

FILE: src/quadric_height_distance.sv
// Point to local quadric height distance.
// in_i carries two kinds of beats. action = load writes word_value into model
// word word_index (0-5 quadric c0..c5, 6-14 rotation row-major, 15-17
// centroid); slots above 17 are dropped, and a load gives no result.
// action = query moves the point into the local frame, evaluates the quadric
// at the local x/y and returns |local z - quadric z| on out_o, saturated.
// Throughput: one beat per cycle while in_i is ready, loads and queries mixed freely. A load is
// seen by every query accepted after it; a query takes along the model words
// it needs, so later loads never disturb queries in flight.
// Pipeline: seven register stages (subtract, rotate multiply, row sum,
// square / linear multiply, quadratic coefficient multiply, sum, abs).
// Backpressure: each stage moves on when it is empty or the next one moves,
// so bubbles close up; when the receiver stalls the pipeline fills and in_i
// drops ready only once all seven stages hold queries.
// Reset clears all model words to zero and empties the pipeline.
module quadric_height_distance #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qhd_in_if.sink    in_i,
  qhd_out_if.source out_o
);

  localparam int WW   = qhd_pkg::WORD_W;
  localparam int SH_W = 2 * WW - FRAC_BITS;  // shifted product width
  localparam int SI_W = qhd_pkg::SAT_IN_W;

  typedef logic signed [SH_W-1:0] shp_t;
  typedef logic signed [2*WW-1:0] prod_t;

  // Model word storage
  qhd_pkg::word_t words_q [qhd_pkg::NUM_WORDS];

  logic in_fire, load_fire, query_fire;

  // Stage valids and ready chain
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic r1, r2, r3, r4, r5, r6, r7;

  assign r7 = !v7_q || out_o.ready;
  assign r6 = !v6_q || r7;
  assign r5 = !v5_q || r6;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;

  assign in_i.ready = r1;
  assign in_fire    = in_i.valid && in_i.ready;
  assign load_fire  = in_fire && (in_i.action == qhd_pkg::ACT_LOAD);
  assign query_fire = in_fire && (in_i.action == qhd_pkg::ACT_QUERY);

  // Model word writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < qhd_pkg::NUM_WORDS; i++) begin
        words_q[i] <= '0;
      end
    end else if (load_fire &&
                 (in_i.word_index < qhd_pkg::IDX_W'(qhd_pkg::NUM_WORDS))) begin
      words_q[in_i.word_index] <= in_i.word_value;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (r1) v1_q <= query_fire;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
      if (r5) v5_q <= v4_q;
      if (r6) v6_q <= v5_q;
      if (r7) v7_q <= v6_q;
    end
  end

  // ---------------- Stage 1: P - G, capture model words ----------------
  qhd_pkg::word_t d1_q    [3];
  qhd_pkg::word_t rot1_q  [qhd_pkg::NUM_ROT];
  qhd_pkg::word_t coef1_q [qhd_pkg::NUM_COEF];
  logic signed [WW:0] diff1 [3];

  always_comb begin
    diff1[0] = (WW+1)'(in_i.point_x) - (WW+1)'(words_q[qhd_pkg::SLOT_CEN]);
    diff1[1] = (WW+1)'(in_i.point_y) - (WW+1)'(words_q[qhd_pkg::SLOT_CEN+1]);
    diff1[2] = (WW+1)'(in_i.point_z) - (WW+1)'(words_q[qhd_pkg::SLOT_CEN+2]);
  end

  always_ff @(posedge clk_i) begin
    if (r1 && query_fire) begin
      for (int c = 0; c < 3; c++) begin
        d1_q[c] <= qhd_pkg::sat32(SI_W'(diff1[c]));
      end
      for (int k = 0; k < qhd_pkg::NUM_ROT; k++) begin
        rot1_q[k] <= words_q[qhd_pkg::SLOT_ROT+k];
      end
      for (int k = 0; k < qhd_pkg::NUM_COEF; k++) begin
        coef1_q[k] <= words_q[k];
      end
    end
  end

  // ---------------- Stage 2: nine rotation products ----------------
  shp_t           m2_q    [qhd_pkg::NUM_ROT];
  qhd_pkg::word_t coef2_q [qhd_pkg::NUM_COEF];
  prod_t          prod2   [qhd_pkg::NUM_ROT];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod2[3*r+c] = prod_t'(rot1_q[3*r+c]) * prod_t'(d1_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      for (int k = 0; k < qhd_pkg::NUM_ROT; k++) begin
        m2_q[k] <= SH_W'(prod2[k] >>> FRAC_BITS);
      end
      coef2_q <= coef1_q;
    end
  end

  // ---------------- Stage 3: row sums -> local coordinates ----------------
  qhd_pkg::word_t loc3_q  [3];
  qhd_pkg::word_t coef3_q [qhd_pkg::NUM_COEF];
  logic signed [SH_W+1:0] acc3 [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc3[r] = (SH_W+2)'(m2_q[3*r]) + (SH_W+2)'(m2_q[3*r+1]) + (SH_W+2)'(m2_q[3*r+2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      for (int r = 0; r < 3; r++) begin
        loc3_q[r] <= qhd_pkg::sat32(SI_W'(acc3[r]));
      end
      coef3_q <= coef2_q;
    end
  end

  // ---------------- Stage 4: x*x, x*y, y*y, c1*x, c2*y ----------------
  qhd_pkg::word_t x2_4_q, xy4_q, y2_4_q, c0_4_q, c3_4_q, c4_4_q, c5_4_q, lz4_q;
  shp_t           p1_4_q, p2_4_q;
  prod_t          px2, pxy, py2, pc1, pc2;

  always_comb begin
    px2 = prod_t'(loc3_q[0]) * prod_t'(loc3_q[0]);
    pxy = prod_t'(loc3_q[0]) * prod_t'(loc3_q[1]);
    py2 = prod_t'(loc3_q[1]) * prod_t'(loc3_q[1]);
    pc1 = prod_t'(coef3_q[1]) * prod_t'(loc3_q[0]);
    pc2 = prod_t'(coef3_q[2]) * prod_t'(loc3_q[1]);
  end

  always_ff @(posedge clk_i) begin
    if (r4 && v3_q) begin
      x2_4_q <= qhd_pkg::sat32(SI_W'(px2 >>> FRAC_BITS));
      xy4_q  <= qhd_pkg::sat32(SI_W'(pxy >>> FRAC_BITS));
      y2_4_q <= qhd_pkg::sat32(SI_W'(py2 >>> FRAC_BITS));
      p1_4_q <= SH_W'(pc1 >>> FRAC_BITS);
      p2_4_q <= SH_W'(pc2 >>> FRAC_BITS);
      c0_4_q <= coef3_q[0];
      c3_4_q <= coef3_q[3];
      c4_4_q <= coef3_q[4];
      c5_4_q <= coef3_q[5];
      lz4_q  <= loc3_q[2];
    end
  end

  // ---------------- Stage 5: quadratic coefficient products ----------------
  shp_t           p1_5_q, p2_5_q, p3_5_q, p4_5_q, p5_5_q;
  qhd_pkg::word_t c0_5_q, lz5_q;
  prod_t          pc3, pc4, pc5;

  always_comb begin
    pc3 = prod_t'(c3_4_q) * prod_t'(x2_4_q);
    pc4 = prod_t'(c4_4_q) * prod_t'(xy4_q);
    pc5 = prod_t'(c5_4_q) * prod_t'(y2_4_q);
  end

  always_ff @(posedge clk_i) begin
    if (r5 && v4_q) begin
      p1_5_q <= p1_4_q;
      p2_5_q <= p2_4_q;
      p3_5_q <= SH_W'(pc3 >>> FRAC_BITS);
      p4_5_q <= SH_W'(pc4 >>> FRAC_BITS);
      p5_5_q <= SH_W'(pc5 >>> FRAC_BITS);
      c0_5_q <= c0_4_q;
      lz5_q  <= lz4_q;
    end
  end

  // ---------------- Stage 6: quadric height z ----------------
  qhd_pkg::word_t z6_q, lz6_q;
  logic signed [SH_W+2:0] zsum6;

  always_comb begin
    zsum6 = (SH_W+3)'(c0_5_q) + (SH_W+3)'(p1_5_q) + (SH_W+3)'(p2_5_q)
          + (SH_W+3)'(p3_5_q) + (SH_W+3)'(p4_5_q) + (SH_W+3)'(p5_5_q);
  end

  always_ff @(posedge clk_i) begin
    if (r6 && v5_q) begin
      z6_q  <= qhd_pkg::sat32(SI_W'(zsum6));
      lz6_q <= lz5_q;
    end
  end

  // ---------------- Stage 7: |lz - z|, saturated output ----------------
  qhd_pkg::dist_t dist7_q;
  logic signed [WW+1:0] diff7, mag7;
  qhd_pkg::dist_t dist7;

  always_comb begin
    diff7 = (WW+2)'(lz6_q) - (WW+2)'(z6_q);
    mag7  = (diff7 < 0) ? -diff7 : diff7;
    if (mag7 > (WW+2)'({1'b0, {qhd_pkg::DIST_W{1'b1}}})) begin
      dist7 = '1;
    end else begin
      dist7 = mag7[qhd_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (r7 && v6_q) begin
      dist7_q <= dist7;
    end
  end

  assign out_o.valid    = v7_q;
  assign out_o.distance = dist7_q;

`ifndef SYNTHESIS
  // A load never puts a beat into the pipeline
  a_load_no_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire |=> !v1_q)
    else $error("load entered the pipeline");

  // An accepted query always occupies stage 1 next cycle
  a_query_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_fire |=> v1_q)
    else $error("query lost at stage 1");

  // A load to a valid slot lands in the model word store
  a_load_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_fire && (in_i.word_index < qhd_pkg::IDX_W'(qhd_pkg::NUM_WORDS)))
    |=> (words_q[$past(in_i.word_index)] == $past(in_i.word_value)))
    else $error("model word write lost");

  // A full stage 6 blocked downstream keeps its beat
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v6_q && !r7) |=> v6_q)
    else $error("stage 6 beat dropped under stall");
`endif

endmodule
